@@ hw/rtl/obox_pkg.sv @@
// shared types for the oriented box overlap test
`timescale 1ns / 1ps
`default_nettype none
package obox_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_AXIS_U_X = 3'd2;
  localparam logic [2:0] REG_AXIS_U_Y = 3'd3;
  localparam logic [2:0] REG_AXIS_V_X = 3'd4;
  localparam logic [2:0] REG_AXIS_V_Y = 3'd5;
  localparam logic [2:0] REG_HALF_U   = 3'd6;
  localparam logic [2:0] REG_HALF_V   = 3'd7;

  localparam int NUM_AXES = 4;

  // reference box as held in configuration
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [15:0] aux;
    logic signed [15:0] auy;
    logic signed [15:0] avx;
    logic signed [15:0] avy;
    logic signed [31:0] hu;
    logic signed [31:0] hv;
  } obox_ref_t;

  // classified candidate, queued between front and back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [30:0]        hu;
    logic [30:0]        hv;
    logic               bad;
  } obox_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/obox_front.sv @@
// front: takes a candidate box and forms center offset and validity
`timescale 1ns / 1ps
`default_nettype none
module obox_front (
  input  wire logic signed [31:0] cand_center_x,
  input  wire logic signed [31:0] cand_center_y,
  input  wire logic signed [15:0] cand_axis_u_x,
  input  wire logic signed [15:0] cand_axis_u_y,
  input  wire logic signed [15:0] cand_axis_v_x,
  input  wire logic signed [15:0] cand_axis_v_y,
  input  wire logic signed [31:0] cand_half_u,
  input  wire logic signed [31:0] cand_half_v,
  input  wire obox_pkg::obox_ref_t ref_box,
  output      obox_pkg::obox_item_t item
);
  import obox_pkg::*;

  always_comb begin
    item.dx  = 33'(cand_center_x) - 33'(ref_box.cx);
    item.dy  = 33'(cand_center_y) - 33'(ref_box.cy);
    item.ux  = cand_axis_u_x;
    item.uy  = cand_axis_u_y;
    item.vx  = cand_axis_v_x;
    item.vy  = cand_axis_v_y;
    item.hu  = cand_half_u[30:0];
    item.hv  = cand_half_v[30:0];
    item.bad = cand_half_u[31] | cand_half_v[31];
  end

endmodule
`default_nettype wire

@@ hw/rtl/obox_queue.sv @@
// small fifo between front and back
`timescale 1ns / 1ps
`default_nettype none
module obox_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire obox_pkg::obox_item_t wr_item,
  output      logic                 full,
  input  wire logic                 pop,
  output      logic                 not_empty,
  output      obox_pkg::obox_item_t rd_item
);
  import obox_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  obox_item_t      mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_item   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/obox_back.sv @@
// back: four stage projection pipeline over the four box axes
`timescale 1ns / 1ps
`default_nettype none
module obox_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_not_empty,
  input  wire obox_pkg::obox_item_t q_item,
  output      logic                 q_pop,
  input  wire obox_pkg::obox_ref_t  ref_box,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic                 out_overlap
);
  import obox_pkg::*;

  logic en;

  // stage 1
  logic signed [15:0] ax [NUM_AXES];
  logic signed [15:0] ay [NUM_AXES];
  logic signed [15:0] oux [NUM_AXES];
  logic signed [15:0] ouy [NUM_AXES];
  logic signed [15:0] ovx [NUM_AXES];
  logic signed [15:0] ovy [NUM_AXES];
  logic [30:0]        h0 [NUM_AXES];
  logic [30:0]        hu0 [NUM_AXES];
  logic [30:0]        hv0 [NUM_AXES];

  logic signed [48:0] pa1_r [NUM_AXES];
  logic signed [48:0] pb1_r [NUM_AXES];
  logic signed [31:0] dua1_r [NUM_AXES];
  logic signed [31:0] dub1_r [NUM_AXES];
  logic signed [31:0] dva1_r [NUM_AXES];
  logic signed [31:0] dvb1_r [NUM_AXES];
  logic [30:0]        h1_r [NUM_AXES];
  logic [30:0]        hu1_r [NUM_AXES];
  logic [30:0]        hv1_r [NUM_AXES];
  logic               bad1_r, v1_r;

  // stage 2
  logic signed [49:0] p2 [NUM_AXES];
  logic signed [32:0] du2 [NUM_AXES];
  logic signed [32:0] dv2 [NUM_AXES];
  logic [49:0]        pm2_r [NUM_AXES];
  logic [31:0]        du2_r [NUM_AXES];
  logic [31:0]        dv2_r [NUM_AXES];
  logic [30:0]        h2_r [NUM_AXES];
  logic [30:0]        hu2_r [NUM_AXES];
  logic [30:0]        hv2_r [NUM_AXES];
  logic               bad2_r, v2_r;

  // stage 3
  logic [62:0]        ru3_r [NUM_AXES];
  logic [62:0]        rv3_r [NUM_AXES];
  logic [49:0]        pm3_r [NUM_AXES];
  logic [30:0]        h3_r [NUM_AXES];
  logic               bad3_r, v3_r;

  // stage 4
  logic [NUM_AXES-1:0] meet;
  logic [64:0]         lhs [NUM_AXES];
  logic [64:0]         rhs [NUM_AXES];
  logic                out_valid_r, overlap_r;

  assign en          = !out_valid_r || !out_stall;
  assign q_pop       = q_not_empty && en;
  assign out_valid   = out_valid_r;
  assign out_overlap = overlap_r;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (k < 2) begin
        oux[k] = q_item.ux;
        ouy[k] = q_item.uy;
        ovx[k] = q_item.vx;
        ovy[k] = q_item.vy;
        hu0[k] = q_item.hu;
        hv0[k] = q_item.hv;
      end else begin
        oux[k] = ref_box.aux;
        ouy[k] = ref_box.auy;
        ovx[k] = ref_box.avx;
        ovy[k] = ref_box.avy;
        hu0[k] = ref_box.hu[30:0];
        hv0[k] = ref_box.hv[30:0];
      end
    end
    ax[0] = ref_box.aux;
    ay[0] = ref_box.auy;
    h0[0] = ref_box.hu[30:0];
    ax[1] = ref_box.avx;
    ay[1] = ref_box.avy;
    h0[1] = ref_box.hv[30:0];
    ax[2] = q_item.ux;
    ay[2] = q_item.uy;
    h0[2] = q_item.hu;
    ax[3] = q_item.vx;
    ay[3] = q_item.vy;
    h0[3] = q_item.hv;
  end

  // projection sign does not matter, so the offset from either center serves
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      p2[k]  = 50'(pa1_r[k]) + 50'(pb1_r[k]);
      du2[k] = 33'(dua1_r[k]) + 33'(dub1_r[k]);
      dv2[k] = 33'(dva1_r[k]) + 33'(dvb1_r[k]);
      lhs[k] = 65'({pm3_r[k], 14'b0});
      rhs[k] = 65'(ru3_r[k]) + 65'(rv3_r[k]) + 65'({h3_r[k], 28'b0});
      meet[k] = (lhs[k] <= rhs[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pa1_r[k]  <= 49'(q_item.dx) * 49'(ax[k]);
        pb1_r[k]  <= 49'(q_item.dy) * 49'(ay[k]);
        dua1_r[k] <= 32'(ax[k]) * 32'(oux[k]);
        dub1_r[k] <= 32'(ay[k]) * 32'(ouy[k]);
        dva1_r[k] <= 32'(ax[k]) * 32'(ovx[k]);
        dvb1_r[k] <= 32'(ay[k]) * 32'(ovy[k]);
        h1_r[k]   <= h0[k];
        hu1_r[k]  <= hu0[k];
        hv1_r[k]  <= hv0[k];

        pm2_r[k]  <= p2[k][49] ? 50'(-p2[k]) : 50'(p2[k]);
        du2_r[k]  <= du2[k][32] ? 32'(-du2[k]) : 32'(du2[k]);
        dv2_r[k]  <= dv2[k][32] ? 32'(-dv2[k]) : 32'(dv2[k]);
        h2_r[k]   <= h1_r[k];
        hu2_r[k]  <= hu1_r[k];
        hv2_r[k]  <= hv1_r[k];

        ru3_r[k]  <= 63'(hu2_r[k]) * 63'(du2_r[k]);
        rv3_r[k]  <= 63'(hv2_r[k]) * 63'(dv2_r[k]);
        pm3_r[k]  <= pm2_r[k];
        h3_r[k]   <= h2_r[k];
      end
      bad1_r    <= q_item.bad | ref_box.hu[31] | ref_box.hv[31];
      bad2_r    <= bad1_r;
      bad3_r    <= bad2_r;
      overlap_r <= !bad3_r && (&meet);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= q_pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/oriented_box_overlap_test.sv @@
// top level: oriented box overlap test with register port
`timescale 1ns / 1ps
`default_nettype none
// Tests each candidate oriented box against a reference box held in registers, by the
// separating axis test on the four box axes; touching counts as overlap, and a negative
// half extent in either box gives no overlap. One item is accepted per cycle while the queue is not full;
// a front stage forms the center offset into a QDEPTH-entry queue, and the back runs a four-stage
// multiply and compare pipeline that advances whenever its output register is empty or being taken.
// Reference registers sit at byte addresses 0 to 28; write them only while no item is in
// flight.
module oriented_box_overlap_test #(
  parameter int QDEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic signed [31:0] in_cand_center_x,
  input  wire logic signed [31:0] in_cand_center_y,
  input  wire logic signed [15:0] in_cand_axis_u_x,
  input  wire logic signed [15:0] in_cand_axis_u_y,
  input  wire logic signed [15:0] in_cand_axis_v_x,
  input  wire logic signed [15:0] in_cand_axis_v_y,
  input  wire logic signed [31:0] in_cand_half_u,
  input  wire logic signed [31:0] in_cand_half_v,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               out_overlap,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);
  import obox_pkg::*;

  obox_ref_t  ref_r;
  obox_item_t f_item, q_item;
  logic       q_full, q_not_empty, q_pop, push;
  logic [2:0] idx;

  assign pready   = 1'b1;
  assign idx      = paddr[4:2];
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r.cx  <= '0;
      ref_r.cy  <= '0;
      ref_r.aux <= 16'sd16384;
      ref_r.auy <= '0;
      ref_r.avx <= '0;
      ref_r.avy <= 16'sd16384;
      ref_r.hu  <= '0;
      ref_r.hv  <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_CENTER_X: ref_r.cx  <= pwdata;
        REG_CENTER_Y: ref_r.cy  <= pwdata;
        REG_AXIS_U_X: ref_r.aux <= pwdata[15:0];
        REG_AXIS_U_Y: ref_r.auy <= pwdata[15:0];
        REG_AXIS_V_X: ref_r.avx <= pwdata[15:0];
        REG_AXIS_V_Y: ref_r.avy <= pwdata[15:0];
        REG_HALF_U:   ref_r.hu  <= pwdata;
        REG_HALF_V:   ref_r.hv  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: prdata = ref_r.cx;
      REG_CENTER_Y: prdata = ref_r.cy;
      REG_AXIS_U_X: prdata = 32'(ref_r.aux);
      REG_AXIS_U_Y: prdata = 32'(ref_r.auy);
      REG_AXIS_V_X: prdata = 32'(ref_r.avx);
      REG_AXIS_V_Y: prdata = 32'(ref_r.avy);
      REG_HALF_U:   prdata = ref_r.hu;
      REG_HALF_V:   prdata = ref_r.hv;
      default:      prdata = '0;
    endcase
  end

  obox_front u_front (
    .cand_center_x (in_cand_center_x),
    .cand_center_y (in_cand_center_y),
    .cand_axis_u_x (in_cand_axis_u_x),
    .cand_axis_u_y (in_cand_axis_u_y),
    .cand_axis_v_x (in_cand_axis_v_x),
    .cand_axis_v_y (in_cand_axis_v_y),
    .cand_half_u   (in_cand_half_u),
    .cand_half_v   (in_cand_half_v),
    .ref_box       (ref_r),
    .item          (f_item)
  );

  obox_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_item   (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_item   (q_item)
  );

  obox_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .ref_box     (ref_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_overlap (out_overlap)
  );

endmodule
`default_nettype wire

@@ hw/rtl/obox_checker.sv @@
// port-level checks for the oriented box overlap test
`timescale 1ns / 1ps
`default_nettype none
module obox_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_overlap,
  input wire logic pready
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // queue is empty after reset, so input is open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_overlap))
    else $error("stalled result changed");

  // no result can appear right after reset when no item was offered
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 !in_valid |=> !out_valid)
    else $error("result without an item");

endmodule

bind oriented_box_overlap_test obox_checker u_obox_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_overlap (out_overlap),
  .pready      (pready)
);
`default_nettype wire

@@ tb/oriented_box_overlap_test_tb.sv @@
// testbench for the oriented box overlap test: predicted overlap flags checked in order
`timescale 1ns / 1ps
module oriented_box_overlap_test_tb;
  import obox_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [31:0] in_cand_center_x, in_cand_center_y, in_cand_half_u, in_cand_half_v;
  logic signed [15:0] in_cand_axis_u_x, in_cand_axis_u_y, in_cand_axis_v_x, in_cand_axis_v_y;
  logic out_valid, out_stall, out_overlap;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  oriented_box_overlap_test u_dut (.*);

  typedef struct {
    logic signed [31:0] cx, cy, hu, hv;
    logic signed [15:0] ux, uy, vx, vy;
  } box_t;

  box_t ref_box;
  bit overlap_q[$];
  int errors = 0, n_items = 0, n_results = 0, n_hits = 0;
  int send_idle = 0, recv_stall = 0, hold_off = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // one interval test along axis (ax, ay) owned by a box of half extent h
  function automatic bit axis_separation_ok(logic signed [63:0] ax, ay, h, dx, dy,
                                            ux, uy, vx, vy, hu, hv);
    logic signed [63:0] p;
    logic [63:0] du, dv, r, hh;
    p = (dx * ax + dy * ay) * 64'sd16384;
    du = mag64(ax * ux + ay * uy);
    dv = mag64(ax * vx + ay * vy);
    r = hu * du + hv * dv;
    hh = h << 28;
    return mag64(p) <= r + hh;
  endfunction

  function automatic bit predict_overlap(box_t c);
    logic signed [63:0] dx, dy;
    dx = 64'(c.cx) - 64'(ref_box.cx);
    dy = 64'(c.cy) - 64'(ref_box.cy);
    if (c.hu < 0 || c.hv < 0 || ref_box.hu < 0 || ref_box.hv < 0) return 0;
    return axis_separation_ok(ref_box.ux, ref_box.uy, ref_box.hu, dx, dy,
                              c.ux, c.uy, c.vx, c.vy, c.hu, c.hv)
        && axis_separation_ok(ref_box.vx, ref_box.vy, ref_box.hv, dx, dy,
                              c.ux, c.uy, c.vx, c.vy, c.hu, c.hv)
        && axis_separation_ok(c.ux, c.uy, c.hu, -dx, -dy,
                              ref_box.ux, ref_box.uy, ref_box.vx, ref_box.vy,
                              ref_box.hu, ref_box.hv)
        && axis_separation_ok(c.vx, c.vy, c.hv, -dx, -dy,
                              ref_box.ux, ref_box.uy, ref_box.vx, ref_box.vy,
                              ref_box.hu, ref_box.hv);
  endfunction

  // result checker and receiver stall generation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (overlap_q.size() == 0) begin
        $display("%0t: unexpected result overlap=%0b", $time, out_overlap);
        errors++;
      end else begin
        bit want;
        want = overlap_q.pop_front();
        if (want) n_hits++;
        if (out_overlap !== want) begin
          $display("%0t: overlap expected %0b actual %0b", $time, want, out_overlap);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_CENTER_X: ref_box.cx = val;
      REG_CENTER_Y: ref_box.cy = val;
      REG_AXIS_U_X: ref_box.ux = val[15:0];
      REG_AXIS_U_Y: ref_box.uy = val[15:0];
      REG_AXIS_V_X: ref_box.vx = val[15:0];
      REG_AXIS_V_Y: ref_box.vy = val[15:0];
      REG_HALF_U:   ref_box.hu = val;
      REG_HALF_V:   ref_box.hv = val;
      default: ;
    endcase
  endtask

  task automatic set_ref(box_t b);
    write_reg(REG_CENTER_X, b.cx);
    write_reg(REG_CENTER_Y, b.cy);
    write_reg(REG_AXIS_U_X, {{16{b.ux[15]}}, b.ux});
    write_reg(REG_AXIS_U_Y, {{16{b.uy[15]}}, b.uy});
    write_reg(REG_AXIS_V_X, {{16{b.vx[15]}}, b.vx});
    write_reg(REG_AXIS_V_Y, {{16{b.vy[15]}}, b.vy});
    write_reg(REG_HALF_U, b.hu);
    write_reg(REG_HALF_V, b.hv);
  endtask

  // called at a falling edge; returns at a falling edge after acceptance, valid still high
  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_cand_center_x <= b.cx; in_cand_center_y <= b.cy;
    in_cand_axis_u_x <= b.ux; in_cand_axis_u_y <= b.uy;
    in_cand_axis_v_x <= b.vx; in_cand_axis_v_y <= b.vy;
    in_cand_half_u <= b.hu; in_cand_half_v <= b.hv;
    do @(posedge clk); while (in_stall);
    overlap_q.push_back(predict_overlap(b));
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (overlap_q.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos(int scale);
    case ($urandom_range(9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 0;
      default: return $signed($urandom_range(2 * scale)) - scale;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_half(int scale);
    case ($urandom_range(11))
      0: return 32'sh7fffffff;
      1: return 0;
      2: return $urandom | 32'h80000000;
      default: return $urandom_range(scale);
    endcase
  endfunction

  function automatic box_t rand_box(int scale);
    box_t b;
    b.cx = rand_pos(scale); b.cy = rand_pos(scale);
    b.ux = rand_axis(); b.uy = rand_axis(); b.vx = rand_axis(); b.vy = rand_axis();
    b.hu = rand_half(scale); b.hv = rand_half(scale);
    return b;
  endfunction

  function automatic box_t axis_box(logic signed [31:0] cx, cy, hu, hv);
    box_t b;
    b.cx = cx; b.cy = cy; b.hu = hu; b.hv = hv;
    b.ux = 16384; b.uy = 0; b.vx = 0; b.vy = 16384;
    return b;
  endfunction

  task automatic test_directed();
    box_t b;
    set_ref(axis_box(0, 0, 32'h20000, 32'h20000));
    send_box(axis_box(32'h40000, 0, 32'h20000, 32'h20000));   // touching edges
    send_box(axis_box(32'h40001, 0, 32'h20000, 32'h20000));   // just apart
    send_box(axis_box(0, 0, 0, 0));                           // point inside
    send_box(axis_box(0, 0, -1, 32'h10000));                  // invalid candidate
    send_box(axis_box(0, 0, 32'h10000, 32'sh80000000));
    send_box(axis_box(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    send_box(axis_box(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0));
    b = axis_box(32'h30000, 32'h30000, 32'h10000, 32'h10000);
    b.ux = 11585; b.uy = 11585; b.vx = -11585; b.vy = 11585;  // rotated 45 degrees
    send_box(b);
    b.ux = 0; b.uy = 0; b.vx = 0; b.vy = 0;                    // degenerate axes
    send_box(b);
    b.ux = 16'sh8000; b.uy = 16'sh7fff; b.vx = 16'sh7fff; b.vy = 16'sh8000;
    send_box(b);
    drain();
    set_ref(axis_box(0, 0, -1, 32'h10000));                   // invalid reference
    send_box(axis_box(0, 0, 32'h10000, 32'h10000));
    drain();
    b = axis_box(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    b.ux = 16'sh8000; b.uy = 16'sh8000; b.vx = 16'sh7fff; b.vy = 16'sh7fff;
    set_ref(b);
    send_box(axis_box(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    send_box(axis_box(0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int n, int sidle, int rstall);
    send_idle = sidle; recv_stall = rstall;
    for (int i = 0; i < n; i++) begin
      int scale;
      if (i % 150 == 0) begin
        drain();
        scale = ($urandom_range(1)) ? 32'h40000 : 32'h4000000;
        set_ref(rand_box(scale));
      end
      scale = ($urandom_range(3) == 0) ? 32'h4000000 : 32'h40000;
      send_box(rand_box(scale));
    end
    drain();
    send_idle = 0; recv_stall = 0;
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 40; i++) send_box(rand_box(32'h40000));
    drain();
  endtask

  initial begin
    rst_n = 0; in_valid = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_cand_center_x = 0; in_cand_center_y = 0; in_cand_half_u = 0; in_cand_half_v = 0;
    in_cand_axis_u_x = 0; in_cand_axis_u_y = 0; in_cand_axis_v_x = 0; in_cand_axis_v_y = 0;
    ref_box = axis_box(0, 0, 0, 0);
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_box(axis_box(0, 0, 0, 0));   // reset reference, point at its center
    drain();
    test_directed();
    test_random(500, 0, 0);
    test_random(450, 86, 0);
    test_random(450, 0, 86);
    test_random(450, 23, 23);
    test_backpressure();
    $display("sent %0d boxes, checked %0d results (%0d overlaps), under idle, stall",
             n_items, n_results, n_hits);
    $display("and long backpressure, with several reference boxes including extremes");
    if (errors == 0 && overlap_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
